FILE: hw/rtl/sapi_pkg.sv
package sapi_pkg;

	// field widths
	localparam int unsigned STEER_W   = 16;
	localparam int unsigned PWM_W     = 16;
	localparam int unsigned ANG_W     = 16;
	localparam int unsigned COUNT_W   = 3;
	localparam int unsigned REGION_W  = 2;

	// apb port
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned RIDX_W    = 3;

	// angle path: centidegrees with 28 fraction bits
	localparam int unsigned ANG_FRAC  = 28;
	localparam int unsigned A_W       = 45;
	localparam int unsigned D_W       = 44;
	localparam int unsigned K_W       = 29;
	localparam logic [K_W-1:0] RAD2CDEG_Q16 = 29'd375493621;

	// interpolation product and divider
	localparam int unsigned PROD_W    = D_W + PWM_W;
	localparam int unsigned DIV_STEPS = PWM_W;

	// divide by ten through reciprocal
	localparam logic [PWM_W-1:0] RECIP10   = 16'd52429;
	localparam int unsigned      RECIP10_SH = 19;
	localparam int unsigned      Q10_W     = 2 * PWM_W - RECIP10_SH;

	localparam logic [COUNT_W-1:0] MIN_POINTS = 3'd2;

	typedef enum logic [RIDX_W-1:0] {
		REG_COUNT  = 3'd0,
		REG_POINT0 = 3'd1,
		REG_POINT1 = 3'd2,
		REG_POINT2 = 3'd3,
		REG_POINT3 = 3'd4,
		REG_POINT4 = 3'd5,
		REG_POINT5 = 3'd6
	} reg_idx_t;

	typedef enum logic [REGION_W-1:0] {
		REGION_INTERP = 2'd0,
		REGION_LOW    = 2'd1,
		REGION_HIGH   = 2'd2
	} region_t;

	// per item control carried alongside the divider
	typedef struct packed {
		logic [ANG_W-1:0] dy;
		logic [PWM_W-1:0] x0;
		logic             dx_neg;
		logic             interp;
		logic [PWM_W-1:0] direct;
		region_t          region;
	} side_t;

	function automatic logic signed [A_W-1:0] ang_scaled(input logic [ANG_W-1:0] y);
		ang_scaled = {y[ANG_W-1], y, {ANG_FRAC{1'b0}}};
	endfunction

endpackage

FILE: hw/rtl/steer_angle_to_pwm_interp.sv
// steering rate (signed q3.12 radians) to servo pwm through a calibration table of up to
// MAX_POINTS (pwm, angle) points sorted by rising angle, written over the apb port. the
// rate is scaled to centidegrees with 28 fraction bits and compared exactly against the
// table. at or below the first angle the first pwm comes out (region 1), at or above the
// last angle in use the last pwm (region 2), both unrounded. in between the segment is
// interpolated with an exact floor, then rounded half up to a multiple of ten and clipped
// at 65535 (region 0); if no segment matches (unsorted table) the last pwm comes out with
// region 0. the datapath is a 23 stage pipeline: one transaction can enter every cycle
// unless the output stalls; the 16 stage restoring divider for the segment slope sets
// that depth. a stalled output freezes the whole pipeline, nothing is dropped.
// registers reset to two points, all zero; configure only while the pipeline is empty.
module steer_angle_to_pwm_interp #(
	parameter int unsigned MAX_POINTS = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// apb configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sapi_pkg::ADDR_W-1:0]      paddr,
	input  logic [sapi_pkg::DATA_W-1:0]      pwdata,
	output logic [sapi_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [sapi_pkg::STEER_W-1:0] steer_rad,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sapi_pkg::PWM_W-1:0]       pwm_value,
	output logic [sapi_pkg::REGION_W-1:0]    region
);
	import sapi_pkg::*;

	localparam int unsigned SEG_N = MAX_POINTS - 1;

	// ---------------- configuration registers ----------------
	logic [COUNT_W-1:0] count_q;
	logic [DATA_W-1:0]  points_q [MAX_POINTS];
	logic [RIDX_W-1:0]  ridx;
	logic               wr_en;
	logic [COUNT_W-1:0] n_eff;

	assign pready = 1'b1;
	assign ridx   = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= MIN_POINTS;
			for (int i = 0; i < MAX_POINTS; i++) begin
				points_q[i] <= '0;
			end
		end else if (wr_en) begin
			if (ridx == REG_COUNT) begin
				count_q <= pwdata[COUNT_W-1:0];
			end
			// writes to points beyond the table depth are dropped
			for (int i = 0; i < MAX_POINTS; i++) begin
				if (ridx == RIDX_W'(REG_POINT0) + RIDX_W'(i)) begin
					points_q[i] <= pwdata;
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (ridx == REG_COUNT) begin
			prdata = DATA_W'(count_q);
		end
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (ridx == RIDX_W'(REG_POINT0) + RIDX_W'(i)) begin
				prdata = points_q[i];
			end
		end
	end

	// point count clamped into the usable range
	always_comb begin
		priority if (count_q < MIN_POINTS) begin
			n_eff = MIN_POINTS;
		end else if (count_q > COUNT_W'(MAX_POINTS)) begin
			n_eff = COUNT_W'(MAX_POINTS);
		end else begin
			n_eff = count_q;
		end
	end

	// ---------------- pipeline flow control ----------------
	// every stage moves together; the last stage is the output register
	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s21, valid_s22, valid_s23;

	assign adv       = !valid_s23 || out_ready;
	assign in_ready  = adv;
	assign out_valid = valid_s23;

	// ---------------- s1: scale radians to centidegrees ----------------
	logic signed [A_W:0]   mul_a;
	logic signed [A_W-1:0] a_s1;

	assign mul_a = steer_rad * $signed({1'b0, RAD2CDEG_Q16});

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= mul_a[A_W-1:0];
		end
	end

	// ---------------- s2: compare against every table angle ----------------
	logic signed [A_W-1:0]  a_s2;
	logic [MAX_POINTS-1:0]  gt_s2, ge_s2;
	logic [MAX_POINTS-1:0]  gt_c, ge_c;

	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			gt_c[i] = a_s1 >  ang_scaled(points_q[i][ANG_W-1:0]);
			ge_c[i] = a_s1 >= ang_scaled(points_q[i][ANG_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2  <= a_s1;
			gt_s2 <= gt_c;
			ge_s2 <= ge_c;
		end
	end

	// ---------------- s3: pick region and segment ----------------
	logic [MAX_POINTS-1:0] last_oh;
	logic [SEG_N-1:0]      hit, seg_oh;
	logic                  is_low, is_high, found;
	logic [PWM_W-1:0]      x0_c, x1_c, xlast_c;
	logic [ANG_W-1:0]      y0_c, y1_c;
	logic signed [A_W-1:0] d_full;
	logic [ANG_W-1:0]      dy_full;
	logic [PWM_W:0]        dx_full;
	logic [PWM_W:0]        dx_abs;
	side_t                 side_c;
	logic [D_W-1:0]        d_s3;
	logic [PWM_W-1:0]      dxmag_s3;
	side_t                 side_s3;

	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			last_oh[i] = (COUNT_W'(i) == n_eff - COUNT_W'(1));
		end
		// segment l holds y[l] < a <= y[l+1], first one wins
		for (int l = 0; l < SEG_N; l++) begin
			hit[l] = gt_s2[l] && !gt_s2[l+1] && (COUNT_W'(l + 1) < n_eff);
		end
		seg_oh  = hit & (~hit + SEG_N'(1));
		found   = |hit;
		is_low  = !gt_s2[0];
		is_high = |(ge_s2 & last_oh);

		x0_c    = '0;
		x1_c    = '0;
		y0_c    = '0;
		y1_c    = '0;
		xlast_c = '0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			xlast_c = xlast_c | (points_q[i][DATA_W-1:ANG_W] & {PWM_W{last_oh[i]}});
		end
		for (int l = 0; l < SEG_N; l++) begin
			x0_c = x0_c | (points_q[l][DATA_W-1:ANG_W]   & {PWM_W{seg_oh[l]}});
			x1_c = x1_c | (points_q[l+1][DATA_W-1:ANG_W] & {PWM_W{seg_oh[l]}});
			y0_c = y0_c | (points_q[l][ANG_W-1:0]        & {ANG_W{seg_oh[l]}});
			y1_c = y1_c | (points_q[l+1][ANG_W-1:0]      & {ANG_W{seg_oh[l]}});
		end

		d_full  = a_s2 - ang_scaled(y0_c);
		dy_full = y1_c - y0_c;
		dx_full = {1'b0, x1_c} - {1'b0, x0_c};
		dx_abs  = dx_full[PWM_W] ? ((PWM_W+1)'(0) - dx_full) : dx_full;

		side_c.dy     = dy_full;
		side_c.x0     = x0_c;
		side_c.dx_neg = dx_full[PWM_W];
		side_c.interp = !is_low && !is_high && found;
		side_c.direct = is_low ? points_q[0][DATA_W-1:ANG_W] : xlast_c;
		priority if (is_low) begin
			side_c.region = REGION_LOW;
		end else if (is_high) begin
			side_c.region = REGION_HIGH;
		end else begin
			side_c.region = REGION_INTERP;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3     <= d_full[D_W-1:0];
			dxmag_s3 <= dx_abs[PWM_W-1:0];
			side_s3  <= side_c;
		end
	end

	// ---------------- s4: offset times pwm span ----------------
	// entry 0 of the divider arrays is s4, entry k is s4+k
	logic [PROD_W-1:0] prod;
	logic [ANG_W-1:0]  div_rem_s  [DIV_STEPS+1];
	logic [PWM_W-1:0]  div_nlo_s  [DIV_STEPS+1];
	logic [PWM_W-1:0]  div_q_s    [DIV_STEPS+1];
	logic              div_lowf_s [DIV_STEPS+1];
	side_t             div_side_s [DIV_STEPS+1];
	logic              div_v_s    [DIV_STEPS+1];

	assign prod = d_s3 * dxmag_s3;

	// the low 28 bits of the divisor are zero: divide the high part, remember the rest
	always_ff @(posedge clk) begin
		if (adv) begin
			div_rem_s[0]  <= prod[PROD_W-1 -: ANG_W];
			div_nlo_s[0]  <= prod[ANG_FRAC +: PWM_W];
			div_q_s[0]    <= '0;
			div_lowf_s[0] <= |prod[ANG_FRAC-1:0];
			div_side_s[0] <= side_s3;
		end
	end

	// ---------------- s5..s20: restoring divider, one quotient bit per stage ----------------
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [ANG_W:0] trial;
		logic [ANG_W:0] diff;
		logic           take;

		assign trial = {div_rem_s[k], div_nlo_s[k][PWM_W-1]};
		assign diff  = trial - {1'b0, div_side_s[k].dy};
		assign take  = trial >= {1'b0, div_side_s[k].dy};

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[k+1]  <= take ? diff[ANG_W-1:0] : trial[ANG_W-1:0];
				div_nlo_s[k+1]  <= {div_nlo_s[k][PWM_W-2:0], 1'b0};
				div_q_s[k+1]    <= {div_q_s[k][PWM_W-2:0], take};
				div_lowf_s[k+1] <= div_lowf_s[k];
				div_side_s[k+1] <= div_side_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				div_v_s[k+1] <= div_v_s[k];
			end
		end
	end

	// ---------------- s21: apply floor and sign ----------------
	logic             inexact;
	logic [PWM_W+1:0] t_full;
	logic [PWM_W-1:0] t_s21;
	side_t            side_s21;

	assign inexact = div_lowf_s[DIV_STEPS] || (div_rem_s[DIV_STEPS] != '0);

	always_comb begin
		if (div_side_s[DIV_STEPS].dx_neg) begin
			t_full = (PWM_W+2)'(div_side_s[DIV_STEPS].x0) - (PWM_W+2)'(div_q_s[DIV_STEPS])
				- (PWM_W+2)'(inexact);
		end else begin
			t_full = (PWM_W+2)'(div_side_s[DIV_STEPS].x0) + (PWM_W+2)'(div_q_s[DIV_STEPS]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s21    <= t_full[PWM_W-1:0];
			side_s21 <= div_side_s[DIV_STEPS];
		end
	end

	// ---------------- s22: divide by ten ----------------
	logic [2*PWM_W-1:0] p10;
	logic [Q10_W-1:0]   q10_s22;
	logic [PWM_W-1:0]   t_s22;
	side_t              side_s22;

	assign p10 = t_s21 * RECIP10;

	always_ff @(posedge clk) begin
		if (adv) begin
			q10_s22  <= p10[2*PWM_W-1:RECIP10_SH];
			t_s22    <= t_s21;
			side_s22 <= side_s21;
		end
	end

	// ---------------- s23: round half up to tens, output register ----------------
	logic [PWM_W:0]   q10x10;
	logic [PWM_W:0]   m_full;
	logic [3:0]       m;
	logic [PWM_W:0]   r_full;
	logic [PWM_W-1:0] r_sat;
	logic [PWM_W-1:0] pwm_s23;
	region_t          region_s23;

	always_comb begin
		q10x10 = (PWM_W+1)'(q10_s22) * (PWM_W+1)'(10);
		m_full = (PWM_W+1)'(t_s22) - q10x10;
		m      = m_full[3:0];
		r_full = (PWM_W+1)'(t_s22) - (PWM_W+1)'(m) + ((m >= 4'd5) ? (PWM_W+1)'(10) : '0);
		r_sat  = r_full[PWM_W] ? '1 : r_full[PWM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pwm_s23    <= side_s22.interp ? r_sat : side_s22.direct;
			region_s23 <= side_s22.region;
		end
	end

	assign pwm_value = pwm_s23;
	assign region    = region_s23;

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			div_v_s[0] <= 1'b0;
			valid_s21  <= 1'b0;
			valid_s22  <= 1'b0;
			valid_s23  <= 1'b0;
		end else if (adv) begin
			valid_s1   <= in_valid;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			div_v_s[0] <= valid_s3;
			valid_s21  <= div_v_s[DIV_STEPS];
			valid_s22  <= valid_s21;
			valid_s23  <= valid_s22;
		end
	end

	// ---------------- assertions ----------------
	// a matched segment always has a rising angle, so the divisor is nonzero
	a_dy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && side_s3.interp |-> side_s3.dy != '0)
		else $error("interpolating segment with zero angle span");

	// the quotient must fit the pwm width: the leading remainder stays below the divisor
	a_div_fits: assert property (@(posedge clk) disable iff (!arst_n)
		div_v_s[0] && div_side_s[0].interp |-> div_rem_s[0] < div_side_s[0].dy)
		else $error("divider quotient overflow");

	// the interpolated value lies between the two segment pwms, no wrap
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_v_s[DIV_STEPS] && div_side_s[DIV_STEPS].interp |-> t_full[PWM_W+1:PWM_W] == 2'b00)
		else $error("interpolated pwm out of range");

	// a stalled output freezes the stage in front of it
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s23 && !out_ready |=> valid_s23 && $stable(valid_s22))
		else $error("pipeline moved under stall");

endmodule
